FILE: rtl/slpe_pkg.sv
// Shared types and constants for the status LED policy engine.
// Used by slpe_phase and status_led_policy_engine; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slpe_pkg;

	typedef enum logic [2:0] {
		PAT_OFF       = 3'd0,
		PAT_ON        = 3'd1,
		PAT_HEARTBEAT = 3'd2,
		PAT_SLOW      = 3'd3,
		PAT_FAST      = 3'd4,
		PAT_DOUBLE    = 3'd5,
		PAT_EVENT     = 3'd6
	} pattern_t;

	typedef enum logic [2:0] {
		POL_BOOT     = 3'd0,
		POL_NORMAL   = 3'd1,
		POL_DEGRADED = 3'd2,
		POL_ARMED    = 3'd3,
		POL_UPDATE   = 3'd4,
		POL_FAULT    = 3'd5,
		POL_FATAL    = 3'd6
	} policy_t;

	typedef enum logic [1:0] {
		MODE_OTHER      = 2'd0,
		MODE_CONFIGURED = 2'd1,
		MODE_ARMED      = 2'd2,
		MODE_FAULT      = 2'd3
	} trig_mode_t;

	typedef enum logic [2:0] {
		REG_SERVICE_INTERVAL = 3'd0,
		REG_PULSE_LENGTH     = 3'd1,
		REG_PULSE_SPACING    = 3'd2,
		REG_STARTUP_GRACE    = 3'd3,
		REG_STALL_LIMIT      = 3'd4
	} reg_index_t;

	// time phases: slow_ph = time mod 1000, fast_ph = time mod 200
	typedef struct packed {
		logic [9:0] slow_ph;
		logic [7:0] fast_ph;
	} phase_t;

	// (time >> 3) / 125 by reciprocal: exact for 29-bit operands
	localparam logic [29:0] PHASE_RECIP = 30'd549755814;
	localparam int          PHASE_SHIFT = 36;

	localparam logic [9:0] HEARTBEAT_ON_MS = 10'd100;
	localparam logic [9:0] SLOW_ON_MS      = 10'd500;
	localparam logic [7:0] FAST_ON_MS      = 8'd100;
	localparam logic [9:0] DOUBLE_GAP_MS   = 10'd200;
	localparam logic [9:0] DOUBLE_END_MS   = 10'd300;

	localparam logic [15:0] RST_SERVICE_INTERVAL = 16'd20;
	localparam logic [15:0] RST_PULSE_LENGTH     = 16'd120;
	localparam logic [15:0] RST_PULSE_SPACING    = 16'd500;
	localparam logic [15:0] RST_STARTUP_GRACE    = 16'd5000;
	localparam logic [15:0] RST_STALL_LIMIT      = 16'd3000;

endpackage

`default_nettype wire

FILE: rtl/status_led_policy_engine.sv
// Status LED policy engine top level: request pipeline, watchdog, pulse
// stretcher, policy select, LED levels and APB register file.
// Depends on slpe_pkg and slpe_phase.
//
// Usage:
//   Service tick requests enter on s_tvalid/s_tready/s_tdata; results leave on
//   m_tvalid/m_tready/m_tdata. A tick closer than service_interval_ms to the
//   last one that gave a result is consumed and gives no result.
//   Each result passes the input stage, the phase stage and the output register
//   in that order after its request is accepted.
//   Throughput: one request per cycle while the receiver takes results; the phase
//   stage holds the single reciprocal multiplier, all per-tick state updates together.
//   A stalled receiver holds the result in the output register; the input and
//   phase stages keep filling until all three are occupied, then s_tready drops.
//   The user must write registers over APB (byte address 4*index) only while the
//   block is idle; the block itself does not enforce this. Reads return the stored 16-bit value.
//   Reset: all stages empty, registers at defaults, policy boot with the system
//   LED on the fast pattern, counters at zero.
`timescale 1ns / 1ps
`default_nettype none

module status_led_policy_engine (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// time_ms[31:0], application_ready[32], second_core_enabled[33],
	// second_core_loops[65:34], trigger_total[97:66], trigger_mode[99:98],
	// fault_sources[102:100], update_active[103], config_gate_open[104]
	input  wire logic [111:0] s_tdata,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// display_policy[2:0], sys_led_pattern[5:3], arm_led_pattern[8:6],
	// fault_led_pattern[11:9], sys_led_on[12], arm_led_on[13], fault_led_on[14],
	// second_core_stalled[15], fault_present[16], configuration_ready[17],
	// event_counter[49:18], pulse_event_total[81:50]
	output      logic [87:0]  m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output      logic [31:0]  prdata,
	output      logic         pready
);

	// configuration
	logic [15:0] service_interval_q;
	logic [15:0] pulse_length_q;
	logic [15:0] pulse_spacing_q;
	logic [15:0] startup_grace_q;
	logic [15:0] stall_limit_q;
	logic        cfg_wr;

	// pipeline
	logic         v1_q;
	logic         v2_q;
	logic         m_valid_q;
	logic [111:0] data_s1;
	logic [111:0] data_s2;
	logic [87:0]  m_data_q;
	logic         ready_o;
	logic         ready2;
	logic         ready1;
	logic         consume;
	logic         take;
	slpe_pkg::phase_t phase;

	// state
	logic [31:0] prev_service_q;
	logic        seen_ready_q;
	logic [31:0] ready_start_q;
	logic [31:0] progress_q;
	logic [31:0] prev_loops_q;
	logic        stall_q;
	logic        health_stale_q;
	logic [31:0] prev_trigger_q;
	logic        pulse_begun_q;
	logic [31:0] pulse_end_q;
	logic [31:0] next_pulse_q;
	logic        fault_q;
	slpe_pkg::policy_t  policy_q;
	slpe_pkg::pattern_t sys_pat_q;
	slpe_pkg::pattern_t arm_pat_q;
	slpe_pkg::pattern_t fault_pat_q;
	logic [31:0] event_count_q;
	logic [31:0] pulse_total_q;

	// request fields at the processing stage
	logic [31:0] now;
	logic        appl_ready;
	logic        core_en;
	logic [31:0] loops;
	logic [31:0] trig;
	slpe_pkg::trig_mode_t mode;
	logic [2:0]  faults;
	logic        upd_active;
	logic        gate;

	// next state and result
	logic [31:0] gap;
	logic        emit;
	logic        seen_ready_d;
	logic [31:0] ready_start_d;
	logic [31:0] progress_d;
	logic [31:0] prev_loops_d;
	logic        stall_d;
	logic        health_stale_d;
	logic [31:0] delta;
	logic        pulse_begun_d;
	logic [31:0] pulse_end_d;
	logic [31:0] next_pulse_d;
	logic        pulse;
	logic        fault_act;
	logic        armed;
	logic        configured;
	slpe_pkg::policy_t  pol;
	slpe_pkg::pattern_t sp;
	slpe_pkg::pattern_t ap;
	slpe_pkg::pattern_t fp;
	logic        pat_chg;
	logic [31:0] event_count_d;
	logic [31:0] pulse_total_d;
	logic        sys_on;
	logic        arm_on;
	logic        fault_on;
	logic [87:0] result;

	function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic level_of(input slpe_pkg::pattern_t p,
			input slpe_pkg::phase_t ph, input logic ev);
		logic lvl;
		case (p)
			slpe_pkg::PAT_OFF:       lvl = 1'b0;
			slpe_pkg::PAT_ON:        lvl = 1'b1;
			slpe_pkg::PAT_HEARTBEAT: lvl = ph.slow_ph < slpe_pkg::HEARTBEAT_ON_MS;
			slpe_pkg::PAT_SLOW:      lvl = ph.slow_ph < slpe_pkg::SLOW_ON_MS;
			slpe_pkg::PAT_FAST:      lvl = ph.fast_ph < slpe_pkg::FAST_ON_MS;
			slpe_pkg::PAT_DOUBLE:    lvl = (ph.slow_ph < slpe_pkg::HEARTBEAT_ON_MS) ||
				((ph.slow_ph >= slpe_pkg::DOUBLE_GAP_MS) &&
				(ph.slow_ph < slpe_pkg::DOUBLE_END_MS));
			slpe_pkg::PAT_EVENT:     lvl = ev;
			default:                 lvl = 1'b0;
		endcase
		return lvl;
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_interval_q <= slpe_pkg::RST_SERVICE_INTERVAL;
			pulse_length_q     <= slpe_pkg::RST_PULSE_LENGTH;
			pulse_spacing_q    <= slpe_pkg::RST_PULSE_SPACING;
			startup_grace_q    <= slpe_pkg::RST_STARTUP_GRACE;
			stall_limit_q      <= slpe_pkg::RST_STALL_LIMIT;
		end else if (cfg_wr) begin
			case (slpe_pkg::reg_index_t'(paddr[4:2]))
				slpe_pkg::REG_SERVICE_INTERVAL: service_interval_q <= pwdata[15:0];
				slpe_pkg::REG_PULSE_LENGTH:     pulse_length_q     <= pwdata[15:0];
				slpe_pkg::REG_PULSE_SPACING:    pulse_spacing_q    <= pwdata[15:0];
				slpe_pkg::REG_STARTUP_GRACE:    startup_grace_q    <= pwdata[15:0];
				slpe_pkg::REG_STALL_LIMIT:      stall_limit_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (slpe_pkg::reg_index_t'(paddr[4:2]))
			slpe_pkg::REG_SERVICE_INTERVAL: prdata = {16'd0, service_interval_q};
			slpe_pkg::REG_PULSE_LENGTH:     prdata = {16'd0, pulse_length_q};
			slpe_pkg::REG_PULSE_SPACING:    prdata = {16'd0, pulse_spacing_q};
			slpe_pkg::REG_STARTUP_GRACE:    prdata = {16'd0, startup_grace_q};
			slpe_pkg::REG_STALL_LIMIT:      prdata = {16'd0, stall_limit_q};
			default:                        prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline control ----------------
	assign ready_o  = !m_valid_q || m_tready;
	assign ready2   = !v2_q || ready_o;
	assign ready1   = !v1_q || ready2;
	assign s_tready = ready1;
	assign consume  = v2_q && ready_o;
	assign take     = consume && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ready1) begin
				v1_q <= s_tvalid;
			end
			if (ready2) begin
				v2_q <= v1_q;
			end
			if (ready_o) begin
				m_valid_q <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready1) begin
			data_s1 <= s_tdata;
		end
		if (ready2 && v1_q) begin
			data_s2 <= data_s1;
		end
		if (take) begin
			m_data_q <= result;
		end
	end

	slpe_phase u_phase (
		.clk     (clk),
		.en      (ready2 && v1_q),
		.time_ms (data_s1[31:0]),
		.phase   (phase)
	);

	// ---------------- tick processing ----------------
	assign now        = data_s2[31:0];
	assign appl_ready = data_s2[32];
	assign core_en    = data_s2[33];
	assign loops      = data_s2[65:34];
	assign trig       = data_s2[97:66];
	assign mode       = slpe_pkg::trig_mode_t'(data_s2[99:98]);
	assign faults     = data_s2[102:100];
	assign upd_active = data_s2[103];
	assign gate       = data_s2[104];

	always_comb begin
		gap  = now - prev_service_q;
		emit = gap >= {16'd0, service_interval_q};

		// second core watchdog
		seen_ready_d   = seen_ready_q;
		ready_start_d  = ready_start_q;
		progress_d     = progress_q;
		prev_loops_d   = prev_loops_q;
		stall_d        = stall_q;
		health_stale_d = health_stale_q;
		if (!appl_ready || !core_en) begin
			seen_ready_d = 1'b0;
			stall_d      = 1'b0;
		end else if (!seen_ready_q) begin
			seen_ready_d  = 1'b1;
			ready_start_d = now;
			progress_d    = now;
			prev_loops_d  = loops;
		end else if (loops != prev_loops_q) begin
			prev_loops_d = loops;
			progress_d   = now;
		end else if (((now - ready_start_q) >= {16'd0, startup_grace_q}) &&
				((now - progress_q) >= {16'd0, stall_limit_q})) begin
			stall_d        = 1'b1;
			health_stale_d = 1'b1;
		end

		// trigger pulse stretcher
		delta = (trig >= prev_trigger_q) ? (trig - prev_trigger_q) : trig;
		pulse_begun_d = pulse_begun_q;
		pulse_end_d   = pulse_end_q;
		next_pulse_d  = next_pulse_q;
		if ((delta != 32'd0) && (!pulse_begun_q || !time_before(now, next_pulse_q))) begin
			pulse_begun_d = 1'b1;
			pulse_end_d   = now + {16'd0, pulse_length_q};
			next_pulse_d  = now + {16'd0, pulse_spacing_q};
		end
		pulse = pulse_begun_d && time_before(now, pulse_end_d);

		fault_act  = (faults != 3'd0) || (mode == slpe_pkg::MODE_FAULT);
		armed      = mode == slpe_pkg::MODE_ARMED;
		configured = mode == slpe_pkg::MODE_CONFIGURED;

		// policy by priority
		ap = slpe_pkg::PAT_OFF;
		fp = slpe_pkg::PAT_OFF;
		if (health_stale_d) begin
			pol = slpe_pkg::POL_FATAL;
			sp  = slpe_pkg::PAT_OFF;
			fp  = slpe_pkg::PAT_FAST;
		end else if (fault_act) begin
			pol = slpe_pkg::POL_FAULT;
			sp  = slpe_pkg::PAT_OFF;
			fp  = slpe_pkg::PAT_ON;
		end else if (upd_active) begin
			pol = slpe_pkg::POL_UPDATE;
			sp  = slpe_pkg::PAT_FAST;
		end else if (!appl_ready) begin
			pol = slpe_pkg::POL_BOOT;
			sp  = slpe_pkg::PAT_FAST;
		end else if (armed) begin
			pol = slpe_pkg::POL_ARMED;
			sp  = slpe_pkg::PAT_HEARTBEAT;
			ap  = pulse ? slpe_pkg::PAT_EVENT : slpe_pkg::PAT_ON;
		end else if (!gate) begin
			pol = slpe_pkg::POL_DEGRADED;
			sp  = slpe_pkg::PAT_DOUBLE;
			ap  = configured ? slpe_pkg::PAT_SLOW : slpe_pkg::PAT_OFF;
		end else begin
			pol = slpe_pkg::POL_NORMAL;
			sp  = slpe_pkg::PAT_HEARTBEAT;
			if (pulse) begin
				ap = slpe_pkg::PAT_EVENT;
			end else begin
				ap = configured ? slpe_pkg::PAT_SLOW : slpe_pkg::PAT_OFF;
			end
		end

		pat_chg = (pol != policy_q) || (sp != sys_pat_q) || (ap != arm_pat_q) ||
			(fp != fault_pat_q);
		pulse_total_d = pulse_total_q + delta;
		event_count_d = event_count_q + delta + 32'(fault_act != fault_q) +
			32'(pat_chg);

		sys_on   = level_of(sp, phase, pulse);
		arm_on   = level_of(ap, phase, pulse && !armed);
		fault_on = level_of(fp, phase, 1'b0);

		result = {6'd0, pulse_total_d, event_count_d, appl_ready && gate, fault_act,
			stall_d, fault_on, arm_on, sys_on, fp, ap, sp, pol};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_service_q <= 32'd0;
			seen_ready_q   <= 1'b0;
			ready_start_q  <= 32'd0;
			progress_q     <= 32'd0;
			prev_loops_q   <= 32'd0;
			stall_q        <= 1'b0;
			health_stale_q <= 1'b0;
			prev_trigger_q <= 32'd0;
			pulse_begun_q  <= 1'b0;
			pulse_end_q    <= 32'd0;
			next_pulse_q   <= 32'd0;
			fault_q        <= 1'b0;
			policy_q       <= slpe_pkg::POL_BOOT;
			sys_pat_q      <= slpe_pkg::PAT_FAST;
			arm_pat_q      <= slpe_pkg::PAT_OFF;
			fault_pat_q    <= slpe_pkg::PAT_OFF;
			event_count_q  <= 32'd0;
			pulse_total_q  <= 32'd0;
		end else if (take) begin
			prev_service_q <= now;
			seen_ready_q   <= seen_ready_d;
			ready_start_q  <= ready_start_d;
			progress_q     <= progress_d;
			prev_loops_q   <= prev_loops_d;
			stall_q        <= stall_d;
			health_stale_q <= health_stale_d;
			prev_trigger_q <= trig;
			pulse_begun_q  <= pulse_begun_d;
			pulse_end_q    <= pulse_end_d;
			next_pulse_q   <= next_pulse_d;
			fault_q        <= fault_act;
			policy_q       <= pol;
			sys_pat_q      <= sp;
			arm_pat_q      <= ap;
			fault_pat_q    <= fp;
			event_count_q  <= event_count_d;
			pulse_total_q  <= pulse_total_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---------------- assertions ----------------
	a_health_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		health_stale_q |=> health_stale_q)
		else $error("health stale flag cleared");

	a_stall_implies_health: assert property (@(posedge clk) disable iff (!arst_n)
		stall_q |-> health_stale_q)
		else $error("stall flag set without health stale latch");

	a_total_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(pulse_total_q) && $stable(event_count_q))
		else $error("counters moved without an emitted result");

	a_fatal_fault_led: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] == slpe_pkg::POL_FATAL)) |->
		((m_tdata[11:9] == slpe_pkg::PAT_FAST) && (m_tdata[5:3] == slpe_pkg::PAT_OFF)))
		else $error("fatal policy with wrong LED patterns");

endmodule

`default_nettype wire

FILE: rtl/slpe_phase.sv
// Blink phase unit: time mod 1000 and time mod 200 over one register stage.
// Depends on slpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slpe_phase (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [31:0]      time_ms,
	output slpe_pkg::phase_t      phase
);

	logic [28:0] x_s1;
	logic [58:0] prod_s1;
	logic [22:0] quot_s1;

	logic [22:0] quot_s2;
	logic [28:0] x_s2;
	logic [2:0]  low_s2;

	logic [28:0] quot_w;
	logic [28:0] quot_x125;
	logic [28:0] rem_full;
	logic [6:0]  rem125;
	logic [6:0]  rem25_w;
	logic [4:0]  rem25;

	assign x_s1    = time_ms[31:3];
	assign prod_s1 = 59'(x_s1) * 59'(slpe_pkg::PHASE_RECIP);
	assign quot_s1 = prod_s1[58:slpe_pkg::PHASE_SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2 <= quot_s1;
			x_s2    <= x_s1;
			low_s2  <= time_ms[2:0];
		end
	end

	always_comb begin
		quot_w    = {6'd0, quot_s2};
		quot_x125 = (quot_w << 7) - (quot_w << 2) + quot_w;
		rem_full  = x_s2 - quot_x125;
		rem125    = rem_full[6:0];
		if (rem125 >= 7'd100) begin
			rem25_w = rem125 - 7'd100;
		end else if (rem125 >= 7'd75) begin
			rem25_w = rem125 - 7'd75;
		end else if (rem125 >= 7'd50) begin
			rem25_w = rem125 - 7'd50;
		end else if (rem125 >= 7'd25) begin
			rem25_w = rem125 - 7'd25;
		end else begin
			rem25_w = rem125;
		end
		rem25         = rem25_w[4:0];
		phase.slow_ph = {rem125, low_s2};
		phase.fast_ph = {rem25, low_s2};
	end

endmodule

`default_nettype wire

FILE: tb/status_led_policy_engine_test.sv
// Self-checking bench for status_led_policy_engine: queued service ticks, a clocked
// driver and monitor with random idling, and an in-bench predictor of every result.
// Depends on slpe_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module status_led_policy_engine_test;

	localparam int STUCK_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	// time_ms, application_ready, second_core_enabled, loops, trigger_total,
	// trigger_mode, fault_sources, update_active, config_gate_open (low bit up)
	typedef struct packed {
		logic [6:0]  pad;
		logic        gate_open;
		logic        update_active;
		logic [2:0]  fault_sources;
		slpe_pkg::trig_mode_t mode;
		logic [31:0] trigger_total;
		logic [31:0] loops;
		logic        core_en;
		logic        application_ready;
		logic [31:0] time_ms;
	} service_req_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic [31:0] pulse_total;
		logic [31:0] event_count;
		logic        cfg_ready;
		logic        fault_present;
		logic        stalled;
		logic        fault_on;
		logic        arm_on;
		logic        sys_on;
		slpe_pkg::pattern_t fault_pat;
		slpe_pkg::pattern_t arm_pat;
		slpe_pkg::pattern_t sys_pat;
		slpe_pkg::policy_t  policy;
	} tick_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	status_led_policy_engine dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// predictor copy of registers and state
	logic [15:0] cfg_interval = slpe_pkg::RST_SERVICE_INTERVAL;
	logic [15:0] cfg_pulse_len = slpe_pkg::RST_PULSE_LENGTH;
	logic [15:0] cfg_spacing = slpe_pkg::RST_PULSE_SPACING;
	logic [15:0] cfg_grace = slpe_pkg::RST_STARTUP_GRACE;
	logic [15:0] cfg_stall = slpe_pkg::RST_STALL_LIMIT;

	logic [31:0] last_service = '0;
	logic        seen_ready = 1'b0;
	logic [31:0] ready_start = '0;
	logic [31:0] progress_at = '0;
	logic [31:0] prev_loops = '0;
	logic        stall_flag = 1'b0;
	logic        stale_latched = 1'b0;
	logic [31:0] prev_trig = '0;
	logic        pulse_begun = 1'b0;
	logic [31:0] pulse_end = '0;
	logic [31:0] next_pulse = '0;
	logic        fault_reg = 1'b0;
	slpe_pkg::policy_t cur_policy = slpe_pkg::POL_BOOT;
	logic [8:0]  cur_pats = {slpe_pkg::PAT_OFF, slpe_pkg::PAT_OFF, slpe_pkg::PAT_FAST};
	logic [31:0] event_count = '0;
	logic [31:0] pulse_total = '0;

	service_req_t pending_ticks[$];
	tick_result_t expected_status[$];
	tick_result_t predicted_status, want, got;
	string        diff;
	int           mismatches = 0;
	int           checked_count = 0;
	int           send_gap = 0, send_run = 0, recv_hold = 0, recv_run = 0;
	int           stuck_cycles = 0;

	// stimulus cursor
	logic [31:0] t_cursor = '0;
	logic [31:0] loops_cur = '0;
	logic [31:0] trig_cur = '0;
	logic [31:0] since_change = '0;

	function automatic bit precedes(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic bit led_level(input slpe_pkg::pattern_t pat, input logic [31:0] t,
			input bit ev);
		logic [31:0] ph;
		ph = t % 1000;
		case (pat)
			slpe_pkg::PAT_ON: return 1'b1;
			slpe_pkg::PAT_HEARTBEAT: return ph < slpe_pkg::HEARTBEAT_ON_MS;
			slpe_pkg::PAT_SLOW: return ph < slpe_pkg::SLOW_ON_MS;
			slpe_pkg::PAT_FAST: return (t % 200) < slpe_pkg::FAST_ON_MS;
			slpe_pkg::PAT_DOUBLE: return ph < slpe_pkg::HEARTBEAT_ON_MS ||
				(ph >= slpe_pkg::DOUBLE_GAP_MS && ph < slpe_pkg::DOUBLE_END_MS);
			slpe_pkg::PAT_EVENT: return ev;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit evaluate_tick(input service_req_t rq, output tick_result_t res);
		logic [31:0] now;
		logic [31:0] trig_delta;
		logic        pulse, fault_act, armed, configured;
		slpe_pkg::policy_t  pol;
		slpe_pkg::pattern_t sp, ap, fp;
		logic [8:0]  pats;
		res = '0;
		now = rq.time_ms;
		if (now - last_service < {16'd0, cfg_interval})
			return 1'b0;
		last_service = now;

		if (!rq.application_ready || !rq.core_en) begin
			seen_ready = 1'b0;
			stall_flag = 1'b0;
		end else if (!seen_ready) begin
			seen_ready = 1'b1;
			ready_start = now;
			progress_at = now;
			prev_loops = rq.loops;
		end else if (rq.loops != prev_loops) begin
			prev_loops = rq.loops;
			progress_at = now;
		end else if (now - ready_start >= {16'd0, cfg_grace} &&
				now - progress_at >= {16'd0, cfg_stall}) begin
			stall_flag = 1'b1;
			stale_latched = 1'b1;
		end

		trig_delta = (rq.trigger_total >= prev_trig) ? rq.trigger_total - prev_trig
			: rq.trigger_total;
		prev_trig = rq.trigger_total;
		if (trig_delta != 0) begin
			pulse_total = pulse_total + trig_delta;
			event_count = event_count + trig_delta;
			if (!pulse_begun || !precedes(now, next_pulse)) begin
				pulse_begun = 1'b1;
				pulse_end = now + cfg_pulse_len;
				next_pulse = now + cfg_spacing;
			end
		end
		pulse = pulse_begun && precedes(now, pulse_end);

		fault_act = rq.fault_sources != 0 || rq.mode == slpe_pkg::MODE_FAULT;
		if (fault_act != fault_reg)
			event_count = event_count + 1;
		fault_reg = fault_act;
		armed = rq.mode == slpe_pkg::MODE_ARMED;
		configured = rq.mode == slpe_pkg::MODE_CONFIGURED;

		ap = slpe_pkg::PAT_OFF;
		fp = slpe_pkg::PAT_OFF;
		if (stale_latched) begin
			pol = slpe_pkg::POL_FATAL; sp = slpe_pkg::PAT_OFF; fp = slpe_pkg::PAT_FAST;
		end else if (fault_act) begin
			pol = slpe_pkg::POL_FAULT; sp = slpe_pkg::PAT_OFF; fp = slpe_pkg::PAT_ON;
		end else if (rq.update_active) begin
			pol = slpe_pkg::POL_UPDATE; sp = slpe_pkg::PAT_FAST;
		end else if (!rq.application_ready) begin
			pol = slpe_pkg::POL_BOOT; sp = slpe_pkg::PAT_FAST;
		end else if (armed) begin
			pol = slpe_pkg::POL_ARMED; sp = slpe_pkg::PAT_HEARTBEAT;
			ap = pulse ? slpe_pkg::PAT_EVENT : slpe_pkg::PAT_ON;
		end else if (!rq.gate_open) begin
			pol = slpe_pkg::POL_DEGRADED; sp = slpe_pkg::PAT_DOUBLE;
			ap = configured ? slpe_pkg::PAT_SLOW : slpe_pkg::PAT_OFF;
		end else begin
			pol = slpe_pkg::POL_NORMAL; sp = slpe_pkg::PAT_HEARTBEAT;
			if (pulse)
				ap = slpe_pkg::PAT_EVENT;
			else if (configured)
				ap = slpe_pkg::PAT_SLOW;
		end

		pats = {fp, ap, sp};
		if (pol != cur_policy || pats != cur_pats)
			event_count = event_count + 1;
		cur_policy = pol;
		cur_pats = pats;

		res.policy = pol;
		res.sys_pat = sp;
		res.arm_pat = ap;
		res.fault_pat = fp;
		res.sys_on = led_level(sp, now, pulse);
		res.arm_on = led_level(ap, now, pulse && !armed);
		res.fault_on = led_level(fp, now, 1'b0);
		res.stalled = stall_flag;
		res.fault_present = fault_act;
		res.cfg_ready = rq.application_ready && rq.gate_open;
		res.event_count = event_count;
		res.pulse_total = pulse_total;
		return 1'b1;
	endfunction

	function automatic int idle_len(inout int run_left);
		int r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			run_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (evaluate_tick(s_tdata, predicted_status))
				expected_status.push_back(predicted_status);
		end
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				s_tdata <= pending_ticks.pop_front();
				s_tvalid <= 1'b1;
				send_gap = idle_len(send_run);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			checked_count++;
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing expected: got %h", checked_count, m_tdata);
			end else begin
				want = expected_status.pop_front();
				got = m_tdata;
				diff = "";
				if (got.policy !== want.policy) diff = {diff, " policy"};
				if (got.sys_pat !== want.sys_pat) diff = {diff, " sys_pat"};
				if (got.arm_pat !== want.arm_pat) diff = {diff, " arm_pat"};
				if (got.fault_pat !== want.fault_pat) diff = {diff, " fault_pat"};
				if (got.sys_on !== want.sys_on) diff = {diff, " sys_on"};
				if (got.arm_on !== want.arm_on) diff = {diff, " arm_on"};
				if (got.fault_on !== want.fault_on) diff = {diff, " fault_on"};
				if (got.stalled !== want.stalled) diff = {diff, " stalled"};
				if (got.fault_present !== want.fault_present) diff = {diff, " fault_present"};
				if (got.cfg_ready !== want.cfg_ready) diff = {diff, " cfg_ready"};
				if (got.event_count !== want.event_count) diff = {diff, " event_count"};
				if (got.pulse_total !== want.pulse_total) diff = {diff, " pulse_total"};
				if (diff != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d differs in%s: expected %h, got %h",
							checked_count, diff, want[81:0], got[81:0]);
				end
			end
		end
		if (recv_hold > 0) begin
			recv_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			recv_hold = idle_len(recv_run);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic write_reg(input slpe_pkg::reg_index_t idx, input logic [15:0] value);
		logic [15:0] upper;
		upper = 16'($urandom);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {upper, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			slpe_pkg::REG_SERVICE_INTERVAL: cfg_interval = value;
			slpe_pkg::REG_PULSE_LENGTH: cfg_pulse_len = value;
			slpe_pkg::REG_PULSE_SPACING: cfg_spacing = value;
			slpe_pkg::REG_STARTUP_GRACE: cfg_grace = value;
			slpe_pkg::REG_STALL_LIMIT: cfg_stall = value;
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [15:0] interval, input logic [15:0] len,
			input logic [15:0] spacing, input logic [15:0] grace, input logic [15:0] limit);
		write_reg(slpe_pkg::REG_SERVICE_INTERVAL, interval);
		write_reg(slpe_pkg::REG_PULSE_LENGTH, len);
		write_reg(slpe_pkg::REG_PULSE_SPACING, spacing);
		write_reg(slpe_pkg::REG_STARTUP_GRACE, grace);
		write_reg(slpe_pkg::REG_STALL_LIMIT, limit);
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || s_tvalid || expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_tick(input logic [31:0] t, input bit ready, input bit en,
			input logic [31:0] loops, input logic [31:0] trig,
			input slpe_pkg::trig_mode_t mode,
			input logic [2:0] faults, input bit upd, input bit gate);
		service_req_t rq;
		rq = '0;
		rq.time_ms = t;
		rq.application_ready = ready;
		rq.core_en = en;
		rq.loops = loops;
		rq.trigger_total = trig;
		rq.mode = mode;
		rq.fault_sources = faults;
		rq.update_active = upd;
		rq.gate_open = gate;
		pending_ticks.push_back(rq);
		t_cursor = t;
		loops_cur = loops;
		trig_cur = trig;
		since_change = '0;
	endtask

	// stall_ok low keeps loop holds too short for the watchdog to fire
	task automatic add_random_ticks(input int count, input bit stall_ok);
		service_req_t rq;
		logic [31:0]  iv, delta;
		int           r, done;
		bit           hold;
		done = 0;
		iv = {16'd0, cfg_interval};
		while (done < count) begin
			rq = '0;
			r = $urandom_range(0, 99);
			if (r < 12)
				delta = $urandom_range(0, iv);
			else if (r < 90)
				delta = iv + $urandom_range(0, 60);
			else if (r < 96)
				delta = iv + $urandom_range(0, 20000);
			else if (r < 98)
				delta = $urandom;
			else
				delta = (32'hFFFF_FFFF - $urandom_range(0, 200)) - t_cursor;
			if (delta >= iv)
				done++;
			t_cursor = t_cursor + delta;
			rq.time_ms = t_cursor;

			if (stall_ok)
				hold = $urandom_range(0, 99) < 60;
			else
				hold = delta < 500 && since_change < 500 && $urandom_range(0, 99) < 30;
			if (hold) begin
				since_change = since_change + delta;
			end else begin
				if ($urandom_range(0, 9) == 0)
					delta = $urandom;
				else
					delta = loops_cur + $urandom_range(1, 1000);
				loops_cur = (delta == loops_cur) ? delta + 1 : delta;
				since_change = '0;
			end
			rq.loops = loops_cur;

			r = $urandom_range(0, 99);
			if (r < 88)
				trig_cur = trig_cur + ((r < 70) ? 0 : $urandom_range(1, 3));
			else if (r < 94)
				trig_cur = trig_cur + $urandom_range(1, 32'h7FFF_FFFF);
			else
				trig_cur = $urandom;
			rq.trigger_total = trig_cur;

			r = $urandom_range(0, 99);
			if (r < 30)
				rq.mode = slpe_pkg::MODE_OTHER;
			else if (r < 55)
				rq.mode = slpe_pkg::MODE_CONFIGURED;
			else if (r < 90)
				rq.mode = slpe_pkg::MODE_ARMED;
			else
				rq.mode = slpe_pkg::MODE_FAULT;
			rq.fault_sources = ($urandom_range(0, 99) < 85) ? 3'd0 : 3'($urandom_range(1, 7));
			rq.update_active = $urandom_range(0, 99) < 8;
			rq.application_ready = $urandom_range(0, 99) < 90;
			rq.core_en = $urandom_range(0, 99) < 92;
			rq.gate_open = $urandom_range(0, 99) < 85;
			pending_ticks.push_back(rq);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_tick(32'd0, 0, 0, 32'd0, 32'd0, slpe_pkg::MODE_OTHER, 3'd0, 0, 0);
		push_tick(32'd25, 0, 1, 32'd1, 32'd0, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);
		push_tick(32'd50, 1, 1, 32'd2, 32'd0, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);
		push_tick(32'd60, 1, 1, 32'd3, 32'd0, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);
		push_tick(32'd80, 1, 1, 32'd4, 32'd0, slpe_pkg::MODE_CONFIGURED, 3'd0, 0, 1);
		push_tick(32'd110, 1, 1, 32'd5, 32'd0, slpe_pkg::MODE_CONFIGURED, 3'd0, 0, 0);
		push_tick(32'd140, 1, 1, 32'd6, 32'd0, slpe_pkg::MODE_OTHER, 3'd0, 0, 0);
		push_tick(32'd170, 1, 1, 32'd7, 32'd1, slpe_pkg::MODE_ARMED, 3'd0, 0, 1);
		push_tick(32'd200, 1, 1, 32'd8, 32'd1, slpe_pkg::MODE_ARMED, 3'd0, 0, 0);
		push_tick(32'd230, 1, 1, 32'd9, 32'd3, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);
		push_tick(32'd300, 1, 1, 32'd10, 32'd3, slpe_pkg::MODE_CONFIGURED, 3'd0, 0, 1);
		push_tick(32'd700, 1, 1, 32'd11, 32'hFFFF_FFFF, slpe_pkg::MODE_ARMED,
			3'd0, 0, 1);
		// count falls: the new count is the increment
		push_tick(32'd730, 1, 1, 32'd12, 32'd5, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);
		push_tick(32'd760, 1, 1, 32'd13, 32'd5, slpe_pkg::MODE_OTHER, 3'd0, 1, 1);
		push_tick(32'd790, 1, 1, 32'd14, 32'd5, slpe_pkg::MODE_OTHER, 3'b010, 1, 1);
		push_tick(32'd820, 1, 1, 32'd15, 32'd5, slpe_pkg::MODE_OTHER, 3'b001, 0, 1);
		push_tick(32'd850, 1, 1, 32'd16, 32'd5, slpe_pkg::MODE_OTHER, 3'b100, 0, 1);
		push_tick(32'd880, 1, 1, 32'd17, 32'd5, slpe_pkg::MODE_FAULT, 3'd0, 0, 1);
		push_tick(32'd910, 0, 0, 32'd18, 32'd5, slpe_pkg::MODE_FAULT, 3'b111, 1, 0);
		push_tick(32'hFFFF_FFF0, 1, 1, 32'hFFFF_FFFF, 32'd5, slpe_pkg::MODE_OTHER,
			3'd0, 0, 1);
		push_tick(32'h0000_0010, 1, 1, 32'd0, 32'd5, slpe_pkg::MODE_CONFIGURED,
			3'd0, 0, 1);
		push_tick(32'd50, 1, 0, 32'd1, 32'd6, slpe_pkg::MODE_ARMED, 3'd0, 0, 1);
		push_tick(32'h8000_0040, 1, 1, 32'd2, 32'd6, slpe_pkg::MODE_OTHER, 3'd0, 0, 1);

		add_random_ticks(200, 0);
		wait_idle();
		set_timing(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		add_random_ticks(170, 0);
		wait_idle();
		set_timing(16'($urandom_range(1, 200)), 16'd0, 16'hFFFF, 16'($urandom),
			16'($urandom_range(5000, 65535)));
		add_random_ticks(170, 0);
		wait_idle();
		set_timing(16'hFFFF, 16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF);
		add_random_ticks(50, 0);
		wait_idle();
		set_timing(16'($urandom_range(0, 100)), 16'($urandom_range(0, 2000)),
			16'($urandom_range(0, 4000)), 16'($urandom),
			16'($urandom_range(5000, 65535)));
		add_random_ticks(180, 0);
		wait_idle();
		// from here on the stale-health latch may set and hold the fatal policy
		set_timing(16'd20, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 800)),
			16'd0, 16'd0);
		add_random_ticks(30, 1);
		wait_idle();
		set_timing(16'($urandom_range(1, 100)), 16'($urandom), 16'($urandom),
			16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
		add_random_ticks(150, 1);
		wait_idle();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: status_led_policy_engine.f
rtl/slpe_pkg.sv
rtl/slpe_phase.sv
rtl/status_led_policy_engine.sv
tb/status_led_policy_engine_test.sv
